// ===== design/pom_pkg.sv =====
package pom_pkg;

  localparam int unsigned VEL_W  = 32;
  localparam int unsigned POS_W  = 48;
  localparam int unsigned ANG_W  = 32;
  localparam int unsigned TRIG_W = 33;
  localparam int unsigned MUL_W  = 33;
  localparam int unsigned PROD_W = 2 * MUL_W;

  localparam int unsigned POM_CORDIC_ITERS = 30;
  localparam int unsigned ITER_W = $clog2(POM_CORDIC_ITERS);

  localparam logic signed [MUL_W-1:0]  POM_TURN_K      = 33'sd2670177;
  localparam logic signed [TRIG_W-1:0] POM_CORDIC_GAIN = 33'sd652032874;

  localparam logic signed [POS_W-1:0] POM_POS_MAX = {1'b0, {(POS_W - 1){1'b1}}};
  localparam logic signed [POS_W-1:0] POM_POS_MIN = {1'b1, {(POS_W - 1){1'b0}}};

  typedef logic signed [VEL_W-1:0]  vel_t;
  typedef logic signed [POS_W-1:0]  pos_t;
  typedef logic        [ANG_W-1:0]  angle_t;
  typedef logic signed [TRIG_W-1:0] trig_t;

  function automatic logic [ANG_W-1:0] pom_atan(input logic [ITER_W-1:0] idx);
    logic [ANG_W-1:0] v;
    case (idx)
      5'd0:    v = 32'd536870912;
      5'd1:    v = 32'd316933406;
      5'd2:    v = 32'd167458907;
      5'd3:    v = 32'd85004756;
      5'd4:    v = 32'd42667331;
      5'd5:    v = 32'd21354465;
      5'd6:    v = 32'd10679838;
      5'd7:    v = 32'd5340245;
      5'd8:    v = 32'd2670163;
      5'd9:    v = 32'd1335087;
      5'd10:   v = 32'd667544;
      5'd11:   v = 32'd333772;
      5'd12:   v = 32'd166886;
      5'd13:   v = 32'd83443;
      5'd14:   v = 32'd41722;
      5'd15:   v = 32'd20861;
      5'd16:   v = 32'd10430;
      5'd17:   v = 32'd5215;
      5'd18:   v = 32'd2608;
      5'd19:   v = 32'd1304;
      5'd20:   v = 32'd652;
      5'd21:   v = 32'd326;
      5'd22:   v = 32'd163;
      5'd23:   v = 32'd81;
      5'd24:   v = 32'd41;
      5'd25:   v = 32'd20;
      5'd26:   v = 32'd10;
      5'd27:   v = 32'd5;
      5'd28:   v = 32'd3;
      5'd29:   v = 32'd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== design/pom_in_if.sv =====
interface pom_in_if;
  import pom_pkg::*;

  logic valid;
  logic ready;
  vel_t vel_x;
  vel_t vel_y;
  vel_t yaw_rate;
  vel_t time_step;

  modport source (output valid, output vel_x, output vel_y, output yaw_rate,
                  output time_step, input ready);
  modport sink (input valid, input vel_x, input vel_y, input yaw_rate,
                input time_step, output ready);
endinterface

// ===== design/pom_out_if.sv =====
interface pom_out_if;
  import pom_pkg::*;

  logic   valid;
  logic   ready;
  pos_t   pos_x_out;
  pos_t   pos_y_out;
  angle_t heading_out;
  logic   bad_step;

  modport source (output valid, output pos_x_out, output pos_y_out,
                  output heading_out, output bad_step, input ready);
  modport sink (input valid, input pos_x_out, input pos_y_out,
                input heading_out, input bad_step, output ready);
endinterface

// ===== design/planar_odometry_midpoint.sv =====
// Planar dead-reckoning odometry with midpoint heading. Each accepted beat on in_i
// (body velocity, yaw rate, time step) advances the stored pose and yields one beat on
// out_o with the new pose. For a valid step, three passes through the single shared
// 33x33 multiplier form the heading change, an iterative CORDIC runs 30 rotations for
// the midpoint sine and cosine, and six more multiplier passes rotate and scale the
// velocity before the S_MX and S_MY states accumulate the position. A time step that
// is zero or negative returns the unchanged pose with bad_step set, going from idle
// straight to the output state. Input is taken only while the block is idle, so a new
// beat is accepted only once the previous one has left for the output register; a
// finished result may wait in the output register while the next beat is accepted.
module planar_odometry_midpoint (
  input logic       clk_i,
  input logic       rst_ni,
  pom_in_if.sink    in_i,
  pom_out_if.source out_o
);
  import pom_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RATE = 4'd1;
  localparam logic [3:0] S_AHI  = 4'd2;
  localparam logic [3:0] S_BLO  = 4'd3;
  localparam logic [3:0] S_ANG  = 4'd4;
  localparam logic [3:0] S_CORD = 4'd5;
  localparam logic [3:0] S_M1   = 4'd6;
  localparam logic [3:0] S_M2   = 4'd7;
  localparam logic [3:0] S_M3   = 4'd8;
  localparam logic [3:0] S_M4   = 4'd9;
  localparam logic [3:0] S_M5   = 4'd10;
  localparam logic [3:0] S_MX   = 4'd11;
  localparam logic [3:0] S_MY   = 4'd12;
  localparam logic [3:0] S_OUT  = 4'd13;

  localparam int unsigned SUM_W = PROD_W - 16 + 1;

  logic [3:0] state_q;
  logic       out_valid_q;
  logic       bad_q;
  pos_t       pos_x_q;
  pos_t       pos_y_q;
  angle_t     heading_q;
  vel_t       vx_q;
  vel_t       vy_q;
  vel_t       w_q;
  vel_t       dt_q;
  logic [31:0]       rate_lo_q;
  logic [MUL_W-1:0]  a_q;
  angle_t            full_q;
  trig_t             c_q;
  trig_t             s_q;
  logic signed [PROD_W-1:0] acc_q;
  logic signed [MUL_W-1:0]  wx_q;
  logic signed [MUL_W-1:0]  wy_q;
  logic signed [PROD_W-1:0] p_q;

  logic signed [MUL_W-1:0]  op_a;
  logic signed [MUL_W-1:0]  op_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] diff;
  logic signed [PROD_W-1:0] summ;
  logic [MUL_W-1:0]         turn;
  logic                     accept;
  logic                     emit;
  logic                     cordic_done;
  trig_t                    cordic_cos;
  trig_t                    cordic_sin;
  angle_t                   mid_angle;
  logic signed [SUM_W-1:0]  sum_x;
  logic signed [SUM_W-1:0]  sum_y;

  function automatic pos_t sat_pos(input logic signed [SUM_W-1:0] v);
    pos_t r;
    if (v > SUM_W'(POM_POS_MAX)) begin
      r = POM_POS_MAX;
    end else if (v < SUM_W'(POM_POS_MIN)) begin
      r = POM_POS_MIN;
    end else begin
      r = v[POS_W-1:0];
    end
    return r;
  endfunction

  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign emit       = (state_q == S_OUT) && (!out_valid_q || out_o.ready);

  // Heading change bits [64:32] of the rate times time step product, modulo 2^33.
  assign turn      = a_q + {1'b0, p_q[63:32]};
  assign mid_angle = heading_q + turn[MUL_W-1:1];

  always_comb begin
    case (state_q)
      S_RATE:  begin op_a = MUL_W'(w_q);  op_b = POM_TURN_K; end
      S_AHI:   begin op_a = p_q[64:32];   op_b = MUL_W'(dt_q); end
      S_BLO:   begin op_a = {1'b0, rate_lo_q};  op_b = MUL_W'(dt_q); end
      S_M1:    begin op_a = MUL_W'(vx_q); op_b = c_q; end
      S_M2:    begin op_a = MUL_W'(vy_q); op_b = s_q; end
      S_M3:    begin op_a = MUL_W'(vx_q); op_b = s_q; end
      S_M4:    begin op_a = MUL_W'(vy_q); op_b = c_q; end
      S_M5:    begin op_a = wx_q;         op_b = MUL_W'(dt_q); end
      S_MX:    begin op_a = wy_q;         op_b = MUL_W'(dt_q); end
      default: begin op_a = '0;           op_b = '0; end
    endcase
  end

  assign prod  = op_a * op_b;
  assign diff  = acc_q - p_q;
  assign summ  = acc_q + p_q;
  assign sum_x = SUM_W'(pos_x_q) + SUM_W'($signed(p_q[PROD_W-1:16]));
  assign sum_y = SUM_W'(pos_y_q) + SUM_W'($signed(p_q[PROD_W-1:16]));

  pom_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == S_ANG),
    .angle_i (mid_angle),
    .done_o  (cordic_done),
    .cos_o   (cordic_cos),
    .sin_o   (cordic_sin)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      bad_q       <= 1'b0;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      heading_q   <= '0;
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            bad_q   <= (in_i.time_step <= 0);
            state_q <= (in_i.time_step <= 0) ? S_OUT : S_RATE;
          end
        end
        S_RATE: state_q <= S_AHI;
        S_AHI:  state_q <= S_BLO;
        S_BLO:  state_q <= S_ANG;
        S_ANG:  state_q <= S_CORD;
        S_CORD: begin
          if (cordic_done) begin
            state_q <= S_M1;
          end
        end
        S_M1: state_q <= S_M2;
        S_M2: state_q <= S_M3;
        S_M3: state_q <= S_M4;
        S_M4: state_q <= S_M5;
        S_M5: state_q <= S_MX;
        S_MX: begin
          pos_x_q <= sat_pos(sum_x);
          state_q <= S_MY;
        end
        S_MY: begin
          pos_y_q   <= sat_pos(sum_y);
          heading_q <= heading_q + full_q;
          state_q   <= S_OUT;
        end
        S_OUT: begin
          if (emit) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= prod;
    if (accept) begin
      vx_q <= in_i.vel_x;
      vy_q <= in_i.vel_y;
      w_q  <= in_i.yaw_rate;
      dt_q <= in_i.time_step;
    end
    if (state_q == S_AHI) begin
      rate_lo_q <= p_q[31:0];
    end
    if (state_q == S_BLO) begin
      a_q <= p_q[MUL_W-1:0];
    end
    if (state_q == S_ANG) begin
      full_q <= turn[ANG_W-1:0];
    end
    if ((state_q == S_CORD) && cordic_done) begin
      c_q <= cordic_cos;
      s_q <= cordic_sin;
    end
    if ((state_q == S_M2) || (state_q == S_M4)) begin
      acc_q <= p_q;
    end
    if (state_q == S_M3) begin
      wx_q <= diff[62:30];
    end
    if (state_q == S_M5) begin
      wy_q <= summ[62:30];
    end
    if (emit) begin
      out_o.pos_x_out   <= pos_x_q;
      out_o.pos_y_out   <= pos_y_q;
      out_o.heading_out <= heading_q;
      out_o.bad_step    <= bad_q;
    end
  end

  assign out_o.valid = out_valid_q;

  a_pos_x_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(pos_x_q) |-> $past(state_q) == S_MX)
    else $error("X position changed outside its update step.");
  a_heading_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(heading_q) |-> $past(state_q) == S_MY)
    else $error("Heading changed outside its update step.");
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_OUT)
    else $error("Result raised without a finished step.");
  a_cordic_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cordic_done |-> state_q == S_CORD)
    else $error("CORDIC finished while the sequencer was not waiting.");

endmodule

// ===== design/pom_cordic.sv =====
module pom_cordic (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  pom_pkg::angle_t angle_i,
  output logic            done_o,
  output pom_pkg::trig_t  cos_o,
  output pom_pkg::trig_t  sin_o
);
  import pom_pkg::*;

  localparam logic [ITER_W-1:0] LastIter = ITER_W'(POM_CORDIC_ITERS - 1);

  logic              busy_q;
  logic              done_q;
  logic [ITER_W-1:0] cnt_q;
  logic [1:0]        quad_q;
  trig_t             x_q;
  trig_t             y_q;
  logic signed [ANG_W-1:0] z_q;

  angle_t     rounded;
  logic [1:0] quad;
  trig_t      dx;
  trig_t      dy;
  logic signed [ANG_W-1:0] step;

  // The nearest quadrant is taken off first so the rotations see at most an eighth turn.
  assign rounded = angle_i + 32'h2000_0000;
  assign quad    = rounded[ANG_W-1:ANG_W-2];
  assign dx      = y_q >>> cnt_q;
  assign dy      = x_q >>> cnt_q;
  assign step    = pom_atan(cnt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == LastIter);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == LastIter) begin
          busy_q <= 1'b0;
        end
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quad_q <= quad;
      z_q    <= angle_i - {quad, {(ANG_W - 2){1'b0}}};
      x_q    <= POM_CORDIC_GAIN;
      y_q    <= '0;
    end else if (busy_q) begin
      if (!z_q[ANG_W-1]) begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - step;
      end else begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + step;
      end
    end
  end

  always_comb begin
    case (quad_q)
      2'd0:    begin cos_o = x_q;  sin_o = y_q;  end
      2'd1:    begin cos_o = -y_q; sin_o = x_q;  end
      2'd2:    begin cos_o = -x_q; sin_o = -y_q; end
      2'd3:    begin cos_o = y_q;  sin_o = -x_q; end
      default: begin cos_o = x_q;  sin_o = y_q;  end
    endcase
  end

  assign done_o = done_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("CORDIC restarted while busy.");
  a_done_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q && $past(busy_q)) else $error("CORDIC done without a run.");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q <= LastIter) else $error("CORDIC count out of range.");

endmodule

// ===== bench/pom_checker.sv =====
`timescale 1ns / 100ps

module pom_checker (
  input  logic clk_i,
  input  logic rst_ni,
  pom_in_if    in_mon_i,
  pom_out_if   out_mon_i,
  output int   mismatch_cnt_o,
  output int   outstanding_o
);
  import pom_pkg::*;

  typedef struct packed {
    pos_t   pos_x;
    pos_t   pos_y;
    angle_t heading;
    logic   bad_step;
  } pose_beat_t;

  localparam int unsigned ROTATIONS = 30;
  localparam int unsigned PRINT_CAP = 30;

  localparam longint ARC_STEP [ROTATIONS] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1
  };

  pose_beat_t expected_poses [$];
  pos_t       track_x;
  pos_t       track_y;
  angle_t     track_heading;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (mismatch_cnt_o < PRINT_CAP) begin
      $display("%0t mismatch on %s: got %0d, want %0d", $time, what, got, want);
    end
    mismatch_cnt_o++;
  endtask

  function automatic void midpoint_trig(input angle_t ang, output longint cos_v,
                                        output longint sin_v);
    angle_t     shifted;
    angle_t     resid;
    logic [1:0] quad;
    longint     x;
    longint     y;
    longint     z;
    longint     dx;
    longint     dy;
    shifted = ang + 32'h2000_0000;
    quad    = shifted[31:30];
    resid   = ang - {quad, 30'b0};
    z       = longint'($signed(resid));
    x       = longint'(POM_CORDIC_GAIN);
    y       = 0;
    for (int i = 0; i < ROTATIONS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - ARC_STEP[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + ARC_STEP[i];
      end
    end
    case (quad)
      2'd0: begin
        cos_v = x;
        sin_v = y;
      end
      2'd1: begin
        cos_v = -y;
        sin_v = x;
      end
      2'd2: begin
        cos_v = -x;
        sin_v = -y;
      end
      default: begin
        cos_v = y;
        sin_v = -x;
      end
    endcase
  endfunction

  function automatic pos_t saturate_pos(input longint v);
    if (v > longint'(POM_POS_MAX)) return POM_POS_MAX;
    if (v < longint'(POM_POS_MIN)) return POM_POS_MIN;
    return pos_t'(v);
  endfunction

  function automatic pose_beat_t advance_pose(input vel_t vx, input vel_t vy,
                                              input vel_t wr, input vel_t dt);
    logic signed [127:0] rate_w;
    logic signed [127:0] dt_w;
    logic signed [127:0] turn_prod;
    longint              rate;
    longint              cos_v;
    longint              sin_v;
    longint              wx;
    longint              wy;
    angle_t              full_turn;
    angle_t              half_turn;
    pose_beat_t          res;
    res.bad_step = 1'b0;
    if ($signed(dt) <= 0) begin
      res.bad_step = 1'b1;
    end else begin
      rate      = longint'(wr) * longint'(POM_TURN_K);
      rate_w    = rate;
      dt_w      = dt;
      turn_prod = rate_w * dt_w;
      full_turn = turn_prod[63:32];
      half_turn = turn_prod[64:33];
      midpoint_trig(track_heading + half_turn, cos_v, sin_v);
      wx = (longint'(vx) * cos_v - longint'(vy) * sin_v) >>> 30;
      wy = (longint'(vx) * sin_v + longint'(vy) * cos_v) >>> 30;
      track_x = saturate_pos(longint'(track_x) + ((wx * longint'(dt)) >>> 16));
      track_y = saturate_pos(longint'(track_y) + ((wy * longint'(dt)) >>> 16));
      track_heading = track_heading + full_turn;
    end
    res.pos_x   = track_x;
    res.pos_y   = track_y;
    res.heading = track_heading;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pose_beat_t want;
    if (!rst_ni) begin
      track_x        = '0;
      track_y        = '0;
      track_heading  = '0;
      mismatch_cnt_o = 0;
      expected_poses.delete();
      outstanding_o <= 0;
    end else begin
      if (out_mon_i.valid && out_mon_i.ready) begin
        if (expected_poses.size() == 0) begin
          report_mismatch("unexpected result beat", 1, 0);
        end else begin
          want = expected_poses.pop_front();
          if (out_mon_i.pos_x_out !== want.pos_x) begin
            report_mismatch("pos_x_out", longint'(out_mon_i.pos_x_out), longint'(want.pos_x));
          end
          if (out_mon_i.pos_y_out !== want.pos_y) begin
            report_mismatch("pos_y_out", longint'(out_mon_i.pos_y_out), longint'(want.pos_y));
          end
          if (out_mon_i.heading_out !== want.heading) begin
            report_mismatch("heading_out", longint'(out_mon_i.heading_out),
                            longint'(want.heading));
          end
          if (out_mon_i.bad_step !== want.bad_step) begin
            report_mismatch("bad_step", longint'(out_mon_i.bad_step), longint'(want.bad_step));
          end
        end
      end
      if (in_mon_i.valid && in_mon_i.ready) begin
        expected_poses.push_back(advance_pose(in_mon_i.vel_x, in_mon_i.vel_y,
                                              in_mon_i.yaw_rate, in_mon_i.time_step));
      end
      outstanding_o <= expected_poses.size();
    end
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import pom_pkg::*;

  typedef enum int {
    PH_DIRECTED,
    PH_FREE,
    PH_SENDER_IDLE,
    PH_RECEIVER_STALL,
    PH_BOTH
  } phase_e;

  localparam int   HANG_LIMIT = 4000;
  localparam int   HOLD_CYCLES = 400;
  localparam int   TAIL_CYCLES = 100;
  localparam vel_t V_MAX = 32'sh7FFF_FFFF;
  localparam vel_t V_MIN = 32'sh8000_0000;
  localparam vel_t ONE_Q16 = 32'sd65536;
  localparam vel_t ONE_SEC = 32'sd16777216;

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   hold_off = 1'b0;
  int     send_idle_pct = 0;
  int     recv_stall_pct = 0;
  int     idle_cycles;
  int     mismatch_cnt;
  int     outstanding;
  phase_e phase = PH_DIRECTED;

  pom_in_if  step_if ();
  pom_out_if pose_if ();

  planar_odometry_midpoint DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (step_if),
    .out_o  (pose_if)
  );

  pom_checker pose_chk (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_mon_i       (step_if),
    .out_mon_i      (pose_if),
    .mismatch_cnt_o (mismatch_cnt),
    .outstanding_o  (outstanding)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  task automatic offer_step(input vel_t vx, input vel_t vy, input vel_t wr, input vel_t dt);
    while ($urandom_range(99) < send_idle_pct) begin
      step_if.valid <= 1'b0;
      @(posedge clk);
    end
    step_if.valid     <= 1'b1;
    step_if.vel_x     <= vx;
    step_if.vel_y     <= vy;
    step_if.yaw_rate  <= wr;
    step_if.time_step <= dt;
    @(posedge clk);
    while (!step_if.ready) @(posedge clk);
  endtask

  task automatic run_random(input int count);
    vel_t vx;
    vel_t vy;
    vel_t wr;
    vel_t dt;
    int   pick;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 25) vx = $urandom;
      else vx = int'($urandom_range(32'd2097152)) - 1048576;
      if ($urandom_range(99) < 25) vy = $urandom;
      else vy = int'($urandom_range(32'd2097152)) - 1048576;
      if ($urandom_range(99) < 25) wr = $urandom;
      else wr = int'($urandom_range(32'd524288)) - 262144;
      pick = $urandom_range(99);
      if (pick < 3) begin
        dt = '0;
      end else if (pick < 5) begin
        dt = -1;
      end else if (pick < 8) begin
        dt = $urandom | 32'h8000_0000;
      end else if (pick < 14) begin
        dt = $urandom & 32'h7FFF_FFFF;
        if (dt == 0) dt = 1;
      end else begin
        dt = $urandom_range(32'd16777216, 32'd1);
      end
      offer_step(vx, vy, wr, dt);
    end
  endtask

  initial begin
    pose_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      pose_if.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    wait (phase == PH_FREE);
    repeat (50) @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < HANG_LIMIT) begin
      @(posedge clk);
      if ((step_if.valid && step_if.ready) || (pose_if.valid && pose_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("tb_top NOT OK");
    $finish;
  end

  initial begin
    step_if.valid     = 1'b0;
    step_if.vel_x     = '0;
    step_if.vel_y     = '0;
    step_if.yaw_rate  = '0;
    step_if.time_step = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    offer_step('0, '0, '0, '0);
    offer_step(V_MAX, V_MAX, V_MAX, -1);
    offer_step(V_MIN, V_MIN, V_MIN, V_MIN);
    offer_step(1, 1, 1, 1);
    offer_step(ONE_Q16, '0, '0, ONE_SEC);
    offer_step('0, ONE_Q16, '0, ONE_SEC);
    offer_step('0, '0, V_MAX, V_MAX);
    offer_step('0, '0, V_MIN, V_MAX);
    offer_step(ONE_Q16, '0, 32'sd102944, ONE_SEC);
    offer_step(V_MIN, V_MAX, V_MIN, 1);
    offer_step(V_MAX, V_MIN, V_MAX, V_MAX);
    repeat (6) offer_step(V_MAX, V_MAX, '0, V_MAX);
    repeat (6) offer_step(V_MIN, V_MIN, '0, V_MAX);

    phase <= PH_FREE;
    run_random(400);

    phase <= PH_SENDER_IDLE;
    send_idle_pct = 59;
    run_random(350);

    phase <= PH_RECEIVER_STALL;
    send_idle_pct = 0;
    recv_stall_pct <= 59;
    run_random(350);

    phase <= PH_BOTH;
    send_idle_pct = 36;
    recv_stall_pct <= 36;
    run_random(450);

    step_if.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_cnt == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// ===== planar_odometry_midpoint.f =====
design/pom_pkg.sv
design/pom_in_if.sv
design/pom_out_if.sv
design/pom_cordic.sv
design/planar_odometry_midpoint.sv
bench/pom_checker.sv
bench/tb_top.sv
